### sv/tsct_pkg.sv
`default_nettype none

package tsct_pkg;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Timers decremented together on one tick, per bank.
    localparam int FAST_GROUP   = 6;
    localparam int MEDIUM_GROUP = 4;
    localparam int SLOW_GROUP   = 2;

    // Phase sequencing.
    localparam logic [2:0] FAST_WRAP   = 3'd5;
    localparam logic [3:0] MEDIUM_WRAP = 4'd10;
    localparam logic [3:0] SLOW_WRAP   = 4'd10;

    // Memory layout: one row per group, FAST_GROUP lanes wide.
    localparam int         FAST_ROWS       = 4;
    localparam int         MEDIUM_ROWS     = 9;
    localparam int         SLOW_ROWS       = 10;
    localparam int         ROWS            = FAST_ROWS + MEDIUM_ROWS + SLOW_ROWS;
    localparam int         ROW_AW          = $clog2(ROWS);
    localparam int         LANE_AW         = $clog2(FAST_GROUP);
    localparam logic [4:0] MEDIUM_BASE_ROW = 5'(FAST_ROWS);
    localparam logic [4:0] SLOW_BASE_ROW   = 5'(FAST_ROWS + MEDIUM_ROWS);

endpackage

`default_nettype wire

### sv/tsct_ram.sv
`default_nettype none

module tsct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/time_sliced_countdown_timer_bank_core.sv
// Bank of countdown timers (fast, medium and slow banks) that stop at zero.
// The counts live in a RAM of 23 rows, one row per decrement group of up to
// six timers, and every item is a read-modify-write of one row.
// Input channel: an item (operation, timer index, load value) is taken at a
// clock edge where start is high and busy is low. A tick advances the phase
// counters and decrements the one group that the new phase selects; a write
// loads one timer; a read returns one timer's count and whether it is zero.
// Sequence: the accept edge issues the row read, and the following cycle
// modifies the row and writes it back. busy is high for that one cycle, so a
// new item is taken only after the previous one has been written back.
// Result channel: o_done is high for exactly one cycle, starting at the edge
// where busy falls, with the result fields. The receiver cannot stall; each
// result must be taken in its strobe cycle.
// Reset (synchronous, active low): phases go to 1, per-row valid bits clear
// so that every timer reads as zero. No clearing pass is needed.
`default_nettype none

module time_sliced_countdown_timer_bank_core #(
    parameter int FAST_TIMERS   = 24,
    parameter int MEDIUM_TIMERS = 36,
    parameter int SLOW_TIMERS   = 19,
    parameter int COUNT_WIDTH   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_operation,
    input  wire logic [6:0]  i_timer_index,
    input  wire logic [15:0] i_load_value,
    output logic             o_done,
    output logic [15:0]      o_read_value,
    output logic             o_timer_expired,
    output logic             o_bad_index
);

    localparam logic [6:0] MediumBase = 7'(FAST_TIMERS);
    localparam logic [6:0] SlowBase   = 7'(FAST_TIMERS + MEDIUM_TIMERS);
    localparam logic [6:0] TotalIdx   = 7'(FAST_TIMERS + MEDIUM_TIMERS + SLOW_TIMERS);
    localparam int         RowWidth   = tsct_pkg::FAST_GROUP * COUNT_WIDTH;

    typedef logic [tsct_pkg::FAST_GROUP-1:0][COUNT_WIDTH-1:0] t_row;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_MOD  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_fast, n_fast;
    logic [3:0] r_med, n_med;
    logic [3:0] r_slow, n_slow;
    logic [tsct_pkg::ROWS-1:0] r_valid;
    logic r_done;

    tsct_pkg::t_op r_op;
    logic [tsct_pkg::ROW_AW-1:0]  r_row;
    logic [tsct_pkg::LANE_AW-1:0] r_lane;
    logic r_bad;
    logic r_dec;
    logic [COUNT_WIDTH-1:0] r_load;
    logic [15:0] r_read_value;
    logic r_expired;
    logic r_bad_out;

    tsct_pkg::t_op w_op;
    logic w_accept;
    logic [2:0] w_nf;
    logic [3:0] w_nm;
    logic [3:0] w_ns;
    logic w_tick_dec;
    logic [tsct_pkg::ROW_AW-1:0] w_tick_row;
    logic [4:0] w_fj;
    logic [5:0] w_mj;
    logic [4:0] w_sj;
    logic [1:0] w_frow;
    logic [tsct_pkg::ROW_AW-1:0]  w_host_row;
    logic [tsct_pkg::LANE_AW-1:0] w_host_lane;
    logic w_bad;
    logic [tsct_pkg::ROW_AW-1:0] w_raddr;
    logic [31:0] w_load32;
    logic [RowWidth-1:0] w_rdata;
    t_row w_old, w_new;
    logic [COUNT_WIDTH-1:0] w_lane_val;
    logic [31:0] w_lane32;
    logic w_we;

    assign busy     = (r_state == S_MOD);
    assign w_accept = start && !busy;
    assign w_op     = tsct_pkg::t_op'(i_operation);
    assign w_load32 = 32'(i_load_value);

    // Phase sequencing and selection of the row that a tick decrements.
    always_comb begin
        n_fast     = r_fast;
        n_med      = r_med;
        n_slow     = r_slow;
        w_nf       = r_fast + 3'd1;
        w_nm       = r_med + 4'd1;
        w_ns       = r_slow + 4'd1;
        w_tick_dec = 1'b0;
        w_tick_row = '0;
        if (w_accept && w_op == tsct_pkg::OP_TICK) begin
            n_fast = w_nf;
            if (w_nf >= 3'd1 && w_nf < tsct_pkg::FAST_WRAP) begin
                w_tick_dec = 1'b1;
                w_tick_row = tsct_pkg::ROW_AW'(w_nf) - 5'd1;
            end else if (w_nf == tsct_pkg::FAST_WRAP) begin
                n_fast = 3'd0;
                n_med  = w_nm;
                if (w_nm >= 4'd1 && w_nm < tsct_pkg::MEDIUM_WRAP) begin
                    w_tick_dec = 1'b1;
                    w_tick_row = tsct_pkg::MEDIUM_BASE_ROW + 5'(w_nm) - 5'd1;
                end else if (w_nm == tsct_pkg::MEDIUM_WRAP) begin
                    n_med  = 4'd0;
                    n_slow = w_ns;
                    if (w_ns >= 4'd1 && w_ns <= tsct_pkg::SLOW_WRAP) begin
                        w_tick_dec = 1'b1;
                        w_tick_row = tsct_pkg::SLOW_BASE_ROW + 5'(w_ns) - 5'd1;
                    end
                    if (w_ns == tsct_pkg::SLOW_WRAP) begin
                        n_slow = 4'd0;
                    end
                end
            end
        end
    end

    // Flat timer index to row and lane.
    always_comb begin
        w_fj   = i_timer_index[4:0];
        w_mj   = 6'(i_timer_index - MediumBase);
        w_sj   = 5'(i_timer_index - SlowBase);
        w_frow = 2'd0;
        for (int r = 1; r < tsct_pkg::FAST_ROWS; r++) begin
            if (w_fj >= 5'(r * tsct_pkg::FAST_GROUP)) begin
                w_frow = 2'(r);
            end
        end
        w_host_row  = '0;
        w_host_lane = '0;
        w_bad       = 1'b0;
        if (i_timer_index < MediumBase) begin
            w_host_row  = 5'(w_frow);
            w_host_lane = 3'(w_fj - 5'(w_frow * tsct_pkg::FAST_GROUP));
        end else if (i_timer_index < SlowBase) begin
            w_host_row  = tsct_pkg::MEDIUM_BASE_ROW + 5'(w_mj[5:2]);
            w_host_lane = 3'(w_mj[1:0]);
        end else if (i_timer_index < TotalIdx) begin
            w_host_row  = tsct_pkg::SLOW_BASE_ROW + 5'(w_sj[4:1]);
            w_host_lane = 3'(w_sj[0]);
        end else begin
            w_bad = (w_op == tsct_pkg::OP_WRITE) || (w_op == tsct_pkg::OP_READ);
        end
    end

    assign w_raddr = (w_op == tsct_pkg::OP_TICK) ? w_tick_row : w_host_row;

    tsct_ram #(
        .WIDTH (RowWidth),
        .DEPTH (tsct_pkg::ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_row),
        .i_wdata (w_new),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Modify step. A row never written since reset reads as all zero.
    always_comb begin
        w_old = r_valid[r_row] ? t_row'(w_rdata) : '0;
        w_new = w_old;
        if (r_op == tsct_pkg::OP_TICK) begin
            for (int l = 0; l < tsct_pkg::FAST_GROUP; l++) begin
                if (w_old[l] != '0) begin
                    w_new[l] = w_old[l] - COUNT_WIDTH'(1);
                end
            end
        end else if (r_op == tsct_pkg::OP_WRITE) begin
            w_new[r_lane] = r_load;
        end
    end

    assign w_lane_val = w_old[r_lane];
    assign w_lane32   = 32'(w_lane_val);
    assign w_we = busy && (((r_op == tsct_pkg::OP_TICK) && r_dec) ||
                           ((r_op == tsct_pkg::OP_WRITE) && !r_bad));

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = w_accept ? S_MOD : S_IDLE;
            S_MOD:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fast  <= 3'd1;
            r_med   <= 4'd1;
            r_slow  <= 4'd1;
            r_valid <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fast  <= n_fast;
            r_med   <= n_med;
            r_slow  <= n_slow;
            r_done  <= busy;
            if (w_we) begin
                r_valid[r_row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= w_op;
            r_row  <= w_raddr;
            r_lane <= w_host_lane;
            r_bad  <= w_bad;
            r_dec  <= w_tick_dec;
            r_load <= w_load32[COUNT_WIDTH-1:0];
        end
        if (busy) begin
            r_bad_out <= r_bad;
            if (r_op == tsct_pkg::OP_READ && !r_bad) begin
                r_read_value <= w_lane32[15:0];
                r_expired    <= (w_lane_val == '0);
            end else begin
                r_read_value <= 16'd0;
                r_expired    <= 1'b0;
            end
        end
    end

    assign o_done          = r_done;
    assign o_read_value    = r_read_value;
    assign o_timer_expired = r_expired;
    assign o_bad_index     = r_bad_out;

endmodule

`default_nettype wire

### sv/tsct_chk.sv
`default_nettype none

module tsct_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_done,
    input wire logic [15:0] o_read_value,
    input wire logic        o_timer_expired,
    input wire logic        o_bad_index
);

    // Every accepted item holds the block busy for exactly one cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted item");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // A result strobe is only raised for an item that was accepted before it.
    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result strobe without a matching accepted item");

    // A rejected index never reports a count.
    a_bad_has_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_bad_index) |-> (o_read_value == 16'd0 && !o_timer_expired))
        else $error("bad index result carries read data");

endmodule

bind time_sliced_countdown_timer_bank_core tsct_chk u_tsct_chk (.*);

`default_nettype wire

### dv/time_sliced_countdown_timer_bank_core_tb.sv
`timescale 1ns / 100ps

module time_sliced_countdown_timer_bank_core_tb;

    localparam int N_FAST       = 24;
    localparam int N_MEDIUM     = 36;
    localparam int N_SLOW       = 19;
    localparam int N_TIMERS     = N_FAST + N_MEDIUM + N_SLOW;
    localparam int RANDOM_ITEMS = 1850;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        tsct_pkg::t_op op;
        logic [6:0]    idx;
        logic [15:0]   load;
    } t_timer_cmd;

    typedef struct {
        logic [15:0] read_value;
        logic        expired;
        logic        bad;
    } t_timer_result;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic [1:0]  i_operation     = 2'd0;
    logic [6:0]  i_timer_index   = 7'd0;
    logic [15:0] i_load_value    = 16'd0;
    logic        busy;
    logic        o_done;
    logic [15:0] o_read_value;
    logic        o_timer_expired;
    logic        o_bad_index;

    t_timer_cmd    cmd_queue[$];
    t_timer_result expected_results[$];
    t_timer_cmd    next_cmd;
    t_timer_result oldest;

    // Shadow copy of the bank.
    logic [2:0]  fast_phase_q;
    logic [3:0]  medium_phase_q;
    logic [3:0]  slow_phase_q;
    logic [15:0] timer_count[N_TIMERS];

    int mismatches   = 0;
    int issued_count = 0;
    int stall_cycles = 0;
    int n_ticks      = 0;
    int n_writes     = 0;
    int n_reads      = 0;
    int n_bad        = 0;
    int n_expired    = 0;
    int n_slow_laps  = 0;
    int n_results    = 0;

    time_sliced_countdown_timer_bank_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_timer_index  (i_timer_index),
        .i_load_value   (i_load_value),
        .o_done         (o_done),
        .o_read_value   (o_read_value),
        .o_timer_expired(o_timer_expired),
        .o_bad_index    (o_bad_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_bank();
        fast_phase_q   = 3'd1;
        medium_phase_q = 4'd1;
        slow_phase_q   = 4'd1;
        for (int i = 0; i < N_TIMERS; i++) begin
            timer_count[i] = 16'd0;
        end
    endfunction

    // Counts stop at zero; lanes past the end of a bank do not exist.
    function automatic void count_down_group(int base, int size, int group, int phase);
        int first;
        first = (phase - 1) * group;
        for (int i = first; i < first + group; i++) begin
            if (i < size && timer_count[base + i] != 16'd0) begin
                timer_count[base + i] = timer_count[base + i] - 16'd1;
            end
        end
    endfunction

    function automatic void advance_phases();
        fast_phase_q = fast_phase_q + 3'd1;
        if (fast_phase_q >= 3'd1 && fast_phase_q < tsct_pkg::FAST_WRAP) begin
            count_down_group(0, N_FAST, tsct_pkg::FAST_GROUP, int'(fast_phase_q));
            return;
        end
        if (fast_phase_q != tsct_pkg::FAST_WRAP) begin
            return;
        end
        fast_phase_q   = 3'd0;
        medium_phase_q = medium_phase_q + 4'd1;
        if (medium_phase_q >= 4'd1 && medium_phase_q < tsct_pkg::MEDIUM_WRAP) begin
            count_down_group(N_FAST, N_MEDIUM, tsct_pkg::MEDIUM_GROUP,
                             int'(medium_phase_q));
            return;
        end
        if (medium_phase_q != tsct_pkg::MEDIUM_WRAP) begin
            return;
        end
        medium_phase_q = 4'd0;
        slow_phase_q   = slow_phase_q + 4'd1;
        if (slow_phase_q >= 4'd1 && slow_phase_q <= tsct_pkg::SLOW_WRAP) begin
            count_down_group(N_FAST + N_MEDIUM, N_SLOW, tsct_pkg::SLOW_GROUP,
                             int'(slow_phase_q));
        end
        if (slow_phase_q == tsct_pkg::SLOW_WRAP) begin
            slow_phase_q = 4'd0;
            n_slow_laps++;
        end
    endfunction

    function automatic t_timer_result apply_timer_cmd(t_timer_cmd c);
        t_timer_result r;
        r = t_timer_result'{read_value: 16'd0, expired: 1'b0, bad: 1'b0};
        case (c.op)
            tsct_pkg::OP_TICK: begin
                advance_phases();
                n_ticks++;
            end
            tsct_pkg::OP_WRITE, tsct_pkg::OP_READ: begin
                if (int'(c.idx) >= N_TIMERS) begin
                    r.bad = 1'b1;
                    n_bad++;
                end else if (c.op == tsct_pkg::OP_WRITE) begin
                    timer_count[c.idx] = c.load;
                    n_writes++;
                end else begin
                    r.read_value = timer_count[c.idx];
                    r.expired    = (timer_count[c.idx] == 16'd0);
                    n_reads++;
                    if (r.expired) begin
                        n_expired++;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic add_cmd(tsct_pkg::t_op op, int idx, int load);
        cmd_queue.push_back(t_timer_cmd'{op: op, idx: 7'(idx), load: 16'(load)});
    endtask

    task automatic flag_mismatch(string what, int got, int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Sender idles at random, except for one long busy stretch in the middle.
    function automatic bit take_a_break();
        if (issued_count >= 700 && issued_count < 1000) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 37;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(apply_timer_cmd(t_timer_cmd'{
                    op: tsct_pkg::t_op'(i_operation),
                    idx: i_timer_index, load: i_load_value}));
            end
            if (!start || !busy) begin
                if (cmd_queue.size() != 0 && !take_a_break()) begin
                    next_cmd = cmd_queue.pop_front();
                    issued_count++;
                    i_operation   <= next_cmd.op;
                    i_timer_index <= next_cmd.idx;
                    i_load_value  <= next_cmd.load;
                    start         <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            n_results++;
            if (expected_results.size() == 0) begin
                flag_mismatch("unexpected result", 1, 0);
            end else begin
                oldest = expected_results.pop_front();
                if (o_read_value !== oldest.read_value) begin
                    flag_mismatch("read_value", o_read_value, oldest.read_value);
                end
                if (o_timer_expired !== oldest.expired) begin
                    flag_mismatch("timer_expired", o_timer_expired, oldest.expired);
                end
                if (o_bad_index !== oldest.bad) begin
                    flag_mismatch("bad_index", o_bad_index, oldest.bad);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int made;
        int pick;
        int idx;
        int load;

        clear_bank();

        // Reads of untouched timers, bad indexes and the unused operation code.
        add_cmd(tsct_pkg::OP_READ, 0, 16'hFFFF);
        add_cmd(tsct_pkg::OP_READ, N_TIMERS - 1, 0);
        add_cmd(tsct_pkg::OP_READ, N_TIMERS, 0);
        add_cmd(tsct_pkg::OP_READ, 127, 16'hFFFF);
        add_cmd(tsct_pkg::OP_WRITE, 127, 16'hFFFF);
        add_cmd(tsct_pkg::OP_WRITE, N_TIMERS, 16'hFFFF);
        add_cmd(tsct_pkg::OP_NONE, 127, 16'hFFFF);
        // Load the edges of every bank, then let the phases run over them.
        add_cmd(tsct_pkg::OP_WRITE, 0, 16'hFFFF);
        add_cmd(tsct_pkg::OP_WRITE, N_FAST - 1, 1);
        add_cmd(tsct_pkg::OP_WRITE, N_FAST, 2);
        add_cmd(tsct_pkg::OP_WRITE, N_FAST + N_MEDIUM - 1, 16'h8000);
        add_cmd(tsct_pkg::OP_WRITE, N_FAST + N_MEDIUM, 1);
        add_cmd(tsct_pkg::OP_WRITE, N_TIMERS - 1, 16'hFFFF);
        add_cmd(tsct_pkg::OP_WRITE, N_TIMERS - 2, 3);
        add_cmd(tsct_pkg::OP_READ, 0, 0);
        for (int i = 0; i < 6; i++) begin
            add_cmd(tsct_pkg::OP_TICK, i * 21, 16'h5A5A);
        end
        add_cmd(tsct_pkg::OP_READ, 0, 0);
        add_cmd(tsct_pkg::OP_READ, N_FAST - 1, 0);
        add_cmd(tsct_pkg::OP_READ, N_FAST, 0);
        add_cmd(tsct_pkg::OP_READ, N_TIMERS - 1, 0);

        // Ticks are the largest share so the slow bank gets to wrap; small loads make
        // timers run out and stick at zero while the host keeps reading them.
        made = 0;
        while (made < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            idx  = ($urandom_range(0, 9) == 0) ? $urandom_range(N_TIMERS, 127)
                                               : $urandom_range(0, N_TIMERS - 1);
            load = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 6) : $urandom_range(0, 65535);
            if (pick < 50) begin
                add_cmd(tsct_pkg::OP_TICK, idx, load);
                made++;
            end else if (pick < 72) begin
                add_cmd(tsct_pkg::OP_WRITE, idx, load);
                made++;
            end else if (pick < 97) begin
                add_cmd(tsct_pkg::OP_READ, idx, load);
                made++;
            end else begin
                add_cmd(tsct_pkg::OP_NONE, idx, load);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start) begin
            @(posedge i_clk);
        end
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d ticks, %0d writes, %0d reads (%0d at zero),",
                 n_results, n_ticks, n_writes, n_reads, n_expired);
        $display("%0d out-of-range accesses, %0d full laps of the slow bank, %0d mismatches.",
                 n_bad, n_slow_laps, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
